// ----- sv/smrt_pkg.sv -----
// Shared types, widths and codes for the sorted multiset rank table.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package smrt_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int DEF_KEY_BITS = 32;

  localparam int ACT_W     = 2;
  localparam int IN_KEY_W  = 32;
  localparam int CNT_W     = 16;
  localparam int RANK_W    = 20;
  localparam int OUT_KEY_W = 32;
  localparam int ST_W      = 2;
  localparam int OP_W      = 3;

  localparam logic [CNT_W-1:0]  COUNT_MAX = '1;
  localparam logic [RANK_W-1:0] RANK_MAX  = '1;

  // action codes; the unused code behaves as a query
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
  localparam logic [ST_W-1:0] ST_SAT    = 2'd3;

  // update commands broadcast to the cell row
  localparam logic [OP_W-1:0] OP_NONE = 3'd0;
  localparam logic [OP_W-1:0] OP_INC  = 3'd1;
  localparam logic [OP_W-1:0] OP_DEC  = 3'd2;
  localparam logic [OP_W-1:0] OP_INS  = 3'd3;
  localparam logic [OP_W-1:0] OP_REM  = 3'd4;

  // compare flags a cell shows its neighbors
  typedef struct packed {
    logic used;
    logic eq;
    logic lt;
  } flag_t;

  typedef struct packed {
    logic [ACT_W-1:0]           action;
    logic signed [IN_KEY_W-1:0] item_key;
  } in_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]            multiplicity;
    logic [RANK_W-1:0]           rank_value;
    logic                        pred_valid;
    logic signed [OUT_KEY_W-1:0] pred_key;
    logic [ST_W-1:0]             status;
  } out_item_t;

endpackage

// ----- sv/smrt_cell.sv -----
// One cell of the sorted table: key, count, running count of smaller elements.
// Depends on smrt_pkg; instantiated in a row by sorted_multiset_rank_table.
`timescale 1ns / 1ps

module smrt_cell #(
  parameter int KEY_BITS = 32,
  parameter int BELOW_W  = 20
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cmp_en,
  input  logic                                upd_en,
  input  logic [smrt_pkg::OP_W-1:0]           op,
  input  logic signed [KEY_BITS-1:0]          k,
  input  logic signed [KEY_BITS-1:0]          l_key,
  input  logic [smrt_pkg::CNT_W-1:0]          l_count,
  input  logic [BELOW_W-1:0]                  l_below,
  input  smrt_pkg::flag_t                     l_flags,
  input  logic signed [KEY_BITS-1:0]          r_key,
  input  logic [smrt_pkg::CNT_W-1:0]          r_count,
  input  logic [BELOW_W-1:0]                  r_below,
  input  logic                                r_used,
  output logic signed [KEY_BITS-1:0]          key_o,
  output logic [smrt_pkg::CNT_W-1:0]          count_o,
  output logic [BELOW_W-1:0]                  below_o,
  output smrt_pkg::flag_t                     flags_o,
  output logic                                live_eq_o
);
  import smrt_pkg::*;

  logic signed [KEY_BITS-1:0] key_r, key_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [BELOW_W-1:0]         below_r, below_nxt;
  logic                       used_r, used_nxt;
  logic                       eq_r, lt_r;
  logic                       gt;
  logic [BELOW_W-1:0]         l_through;

  assign gt        = used_r & ~eq_r & ~lt_r;
  assign l_through = l_below + BELOW_W'(l_count);
  assign live_eq_o = used_r && (key_r == k);

  always_comb begin
    key_nxt   = key_r;
    count_nxt = count_r;
    below_nxt = below_r;
    used_nxt  = used_r;
    case (op)
      OP_INC: begin
        if (eq_r) count_nxt = count_r + CNT_W'(1);
        else if (gt) below_nxt = below_r + BELOW_W'(1);
      end
      OP_DEC: begin
        if (eq_r) count_nxt = count_r - CNT_W'(1);
        else if (gt) below_nxt = below_r - BELOW_W'(1);
      end
      OP_INS: begin
        if (!lt_r) begin
          if (l_flags.lt) begin
            // first cell not below the key takes the new entry
            key_nxt   = k;
            count_nxt = CNT_W'(1);
            below_nxt = l_through;
            used_nxt  = 1'b1;
          end else if (l_flags.used) begin
            key_nxt   = l_key;
            count_nxt = l_count;
            below_nxt = l_below + BELOW_W'(1);
            used_nxt  = 1'b1;
          end
        end
      end
      OP_REM: begin
        if (!lt_r) begin
          key_nxt   = r_key;
          count_nxt = r_count;
          below_nxt = r_below - BELOW_W'(1);
          used_nxt  = r_used;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      eq_r   <= 1'b0;
      lt_r   <= 1'b0;
    end else begin
      if (cmp_en) begin
        eq_r <= live_eq_o;
        lt_r <= used_r && (key_r < k);
      end
      if (upd_en) used_r <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_en) begin
      key_r   <= key_nxt;
      count_r <= count_nxt;
      below_r <= below_nxt;
    end
  end

  assign key_o   = key_r;
  assign count_o = count_r;
  assign below_o = below_r;
  assign flags_o = '{used: used_r, eq: eq_r, lt: lt_r};

endmodule

// ----- sv/sorted_multiset_rank_table.sv -----
// Top level of the sorted multiset rank table: control sequence and result mux.
// Depends on smrt_pkg and smrt_cell.
`timescale 1ns / 1ps

// Channel  | Ports                  | Handshake
// ---------+------------------------+------------------------------------------
// input    | start, busy, in_item   | item taken at a clock edge with start & !busy
// result   | out_valid, out_item    | one-cycle strobe, receiver cannot stall
//
// Every item passes the compare, update and result states after it is taken.
// The sequence is set by the shared compare/update pass over the cell row;
// busy stays high through those states and the result strobes in the
// cycle after, when busy is already low again and the next item may enter.
// Reset (rst_n low, synchronous) empties the table at once through the
// cells' in-use flags; no clearing pass is needed.

module sorted_multiset_rank_table #(
  parameter int CAPACITY = smrt_pkg::DEF_CAPACITY,
  parameter int KEY_BITS = smrt_pkg::DEF_KEY_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  smrt_pkg::in_item_t  in_item,
  output logic                out_valid,
  output smrt_pkg::out_item_t out_item
);
  import smrt_pkg::*;

  // sum of all counts fits without wrap
  localparam int BELOW_W = CNT_W + $clog2(CAPACITY + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_RES  = 2'd3;

  logic [1:0]                 state_r, state_nxt;
  logic signed [KEY_BITS-1:0] key_r;
  logic [ACT_W-1:0]           act_r;
  logic [ST_W-1:0]            status_r, status_nxt;
  logic [OP_W-1:0]            op;
  out_item_t                  out_r, out_nxt;
  logic                       out_valid_r;

  logic signed [KEY_BITS-1:0] cell_key   [CAPACITY];
  logic [CNT_W-1:0]           cell_count [CAPACITY];
  logic [BELOW_W-1:0]         cell_below [CAPACITY];
  flag_t                      cell_flags [CAPACITY];
  logic [CAPACITY-1:0]        live_eq;
  logic [CAPACITY-1:0]        eq_vec;

  logic found, sat_hit, one_hit, full;
  logic accept;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  // ---------------------------------------------------------------- cell row
  // Left of cell 0 sits a boundary that counts as smaller than every key but
  // holds nothing; right of the last cell sits an empty boundary.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [KEY_BITS-1:0] l_key, r_key;
    logic [CNT_W-1:0]           l_count, r_count;
    logic [BELOW_W-1:0]         l_below, r_below;
    flag_t                      l_flags;
    logic                       r_used;

    if (i == 0) begin : g_lb
      assign l_key   = '0;
      assign l_count = '0;
      assign l_below = '0;
      assign l_flags = '{used: 1'b0, eq: 1'b0, lt: 1'b1};
    end else begin : g_ln
      assign l_key   = cell_key[i-1];
      assign l_count = cell_count[i-1];
      assign l_below = cell_below[i-1];
      assign l_flags = cell_flags[i-1];
    end

    if (i == CAPACITY - 1) begin : g_rb
      assign r_key   = '0;
      assign r_count = '0;
      assign r_below = '0;
      assign r_used  = 1'b0;
    end else begin : g_rn
      assign r_key   = cell_key[i+1];
      assign r_count = cell_count[i+1];
      assign r_below = cell_below[i+1];
      assign r_used  = cell_flags[i+1].used;
    end

    smrt_cell #(
      .KEY_BITS(KEY_BITS),
      .BELOW_W (BELOW_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmp_en   (state_r == S_CMP),
      .upd_en   (state_r == S_UPD),
      .op       (op),
      .k        (key_r),
      .l_key    (l_key),
      .l_count  (l_count),
      .l_below  (l_below),
      .l_flags  (l_flags),
      .r_key    (r_key),
      .r_count  (r_count),
      .r_below  (r_below),
      .r_used   (r_used),
      .key_o    (cell_key[i]),
      .count_o  (cell_count[i]),
      .below_o  (cell_below[i]),
      .flags_o  (cell_flags[i]),
      .live_eq_o(live_eq[i])
    );

    assign eq_vec[i] = cell_flags[i].eq;
  end

  // ----------------------------------------------------------- decide update
  // Reduce the registered compare flags, then pick one command for the row.
  always_comb begin
    found   = 1'b0;
    sat_hit = 1'b0;
    one_hit = 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      found   = found | eq_vec[i];
      sat_hit = sat_hit | (eq_vec[i] && (cell_count[i] == COUNT_MAX));
      one_hit = one_hit | (eq_vec[i] && (cell_count[i] == CNT_W'(1)));
    end
    full = cell_flags[CAPACITY-1].used;
  end

  always_comb begin
    op         = OP_NONE;
    status_nxt = ST_OK;
    if (state_r == S_UPD) begin
      case (act_r)
        ACT_INSERT: begin
          if (found) begin
            if (sat_hit) status_nxt = ST_SAT;
            else op = OP_INC;
          end else if (full) begin
            status_nxt = ST_FULL;
          end else begin
            op = OP_INS;
          end
        end
        ACT_DELETE: begin
          if (!found) status_nxt = ST_ABSENT;
          else if (one_hit) op = OP_REM;
          else op = OP_DEC;
        end
        default: ;  // query, and the unused code, leave the table alone
      endcase
    end
  end

  // ------------------------------------------------------------ result mux
  // The table is already updated; the matching cell (at most one) supplies
  // count and rank, its left neighbor the predecessor.
  always_comb begin
    logic [CNT_W-1:0]           mult;
    logic [BELOW_W-1:0]         below;
    logic                       hit;
    logic                       pvalid;
    logic signed [KEY_BITS-1:0] pkey;
    logic [BELOW_W:0]           rank_full;

    mult   = '0;
    below  = '0;
    hit    = 1'b0;
    pvalid = 1'b0;
    pkey   = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (live_eq[i]) begin
        hit   = 1'b1;
        mult  = mult | cell_count[i];
        below = below | cell_below[i];
      end
    end
    // cell 0 has no left neighbor
    for (int i = 1; i < CAPACITY; i++) begin
      if (live_eq[i] && cell_flags[i-1].used) begin
        pvalid = 1'b1;
        pkey   = pkey | cell_key[i-1];
      end
    end
    rank_full = {1'b0, below} + (BELOW_W + 1)'(1);

    out_nxt.multiplicity = mult;
    if (!hit) out_nxt.rank_value = RANK_W'(1);
    else if (rank_full > (BELOW_W + 1)'(RANK_MAX)) out_nxt.rank_value = RANK_MAX;
    else out_nxt.rank_value = RANK_W'(rank_full);
    out_nxt.pred_valid = pvalid;
    out_nxt.pred_key   = OUT_KEY_W'(pkey);
    out_nxt.status     = status_r;
  end

  // ---------------------------------------------------------------- control
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_CMP;
      S_CMP:   state_nxt = S_UPD;
      S_UPD:   state_nxt = S_RES;
      S_RES:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_RES);
    end
  end

  // hold the item's key (sign-extended or wrapped to the key width) and action
  always_ff @(posedge clk) begin
    if (accept) begin
      key_r <= KEY_BITS'(in_item.item_key);
      act_r <= in_item.action;
    end
    if (state_r == S_UPD) status_r <= status_nxt;
    if (state_r == S_RES) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // ------------------------------------------------------------- assertions
  // A key may sit in one cell only.
  a_unique_key: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UPD) |-> $onehot0(eq_vec))
    else $error("key matched in more than one cell");

  // A result follows the result cycle and nothing else.
  a_strobe_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_RES))
    else $error("result strobe outside the sequence");

  // A full-table refusal describes an absent key.
  a_full_absent: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == ST_FULL) |->
      (out_item.multiplicity == '0 && out_item.rank_value == RANK_W'(1)))
    else $error("full-table result shows a present key");

  // A predecessor is reported only for a present key.
  a_pred_present: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.pred_valid) |-> (out_item.multiplicity != '0))
    else $error("predecessor for an absent key");

endmodule
